/* src/mpr_pkg.sv */
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types and constants for the masked pixel to RGB888 converter.
// ----------------------------------------------------------------------------
package mpr_pkg;

    // Width of one output colour channel
    localparam int CHAN_BITS = 8;

    // Quotient bits resolved per divider stage
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CHAN_BITS / BITS_PER_STAGE;

    // Register stages in the mask alignment front end
    localparam int ALIGN_STAGES = 2;

    // Pipeline depth: alignment, product stage, then the divider stages
    localparam int LATENCY = ALIGN_STAGES + 1 + DIV_STAGES;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2
    } reg_index_t;

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

endpackage

/* src/masked_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// masked_pixel_to_rgb888
// Converts a packed pixel to 8-bit red, green and blue using per-channel
// bit masks.
// ----------------------------------------------------------------------------
// One pixel is accepted every cycle unless the output stalls; in the pipeline
// two stages align the field to the mask's lowest set bit,
// one forms field * 255, and four stages of a restoring divider resolve two
// quotient bits each. The whole pipeline holds when the output is stalled,
// so input tready follows output tready whenever a result is waiting.
// Masks are written through the cfg channel, which is always ready; write
// them only while no pixel is in flight. A zero mask gives zero.
module masked_pixel_to_rgb888 #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // cfg channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mpr_pkg::reg_index_t cfg_index,
    input  logic [31:0]         cfg_data,
    // pixel input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // [31:0] packed_pixel
    // RGB output
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata    // [7:0] red_out, [15:8] green_out,
                                                // [23:16] blue_out
);
    import mpr_pkg::*;

    logic [31:0]           red_sel_reg;
    logic [31:0]           green_sel_reg;
    logic [31:0]           blue_sel_reg;
    logic [LATENCY-1:0]    valid_reg;
    logic                  en;

    logic [31:0]           mask_sel  [3];
    logic [PIXEL_BITS-1:0] field     [3];
    logic [PIXEL_BITS-1:0] den       [3];
    logic                  zero      [3];
    logic [CHAN_BITS-1:0]  chan      [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_sel_reg   <= RED_MASK_RST;
            green_sel_reg <= GREEN_MASK_RST;
            blue_sel_reg  <= BLUE_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RED_MASK:   red_sel_reg   <= cfg_data;
                REG_GREEN_MASK: green_sel_reg <= cfg_data;
                REG_BLUE_MASK:  blue_sel_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Whole pipeline advances unless a result is held at the output
    assign en            = !valid_reg[LATENCY-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], s_axis_tvalid};
        end
    end

    assign mask_sel[0] = red_sel_reg;
    assign mask_sel[1] = green_sel_reg;
    assign mask_sel[2] = blue_sel_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        mpr_align #(
            .PIXEL_BITS(PIXEL_BITS)
        ) u_align (
            .clk   (clk),
            .en    (en),
            .pixel (s_axis_tdata),
            .mask  (mask_sel[c]),
            .field (field[c]),
            .den   (den[c]),
            .zero  (zero[c])
        );

        mpr_scale_div #(
            .PIXEL_BITS(PIXEL_BITS)
        ) u_div (
            .clk   (clk),
            .en    (en),
            .field (field[c]),
            .den   (den[c]),
            .zero  (zero[c]),
            .chan  (chan[c])
        );
    end

    assign m_axis_tvalid = valid_reg[LATENCY-1];
    assign m_axis_tdata  = {chan[2], chan[1], chan[0]};

endmodule

/* src/mpr_align.sv */
// ----------------------------------------------------------------------------
// mpr_align
// Two-stage front end for one channel: finds the mask's lowest set bit,
// then shifts pixel and mask down and extracts the field.
// ----------------------------------------------------------------------------
module mpr_align #(
    parameter int PIXEL_BITS = 32,
    localparam int SH_BITS   = $clog2(PIXEL_BITS)
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [31:0]           pixel,
    input  logic [31:0]           mask,
    output logic [PIXEL_BITS-1:0] field,
    output logic [PIXEL_BITS-1:0] den,
    output logic                  zero
);
    import mpr_pkg::*;

    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] mask_reg;
    logic [SH_BITS-1:0]    sh_reg;
    logic                  zero1_reg;
    logic [SH_BITS-1:0]    sh_next;

    logic [PIXEL_BITS-1:0] field_reg;
    logic [PIXEL_BITS-1:0] den_reg;
    logic                  zero2_reg;
    logic [PIXEL_BITS-1:0] mask_sh;

    // Trailing-zero count; the lowest set bit is written last and wins
    always_comb
    begin
        sh_next = '0;
        for (int i = PIXEL_BITS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                sh_next = SH_BITS'(i);
            end
        end
    end

    assign mask_sh = mask_reg >> sh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg   <= pixel[PIXEL_BITS-1:0];
            mask_reg  <= mask[PIXEL_BITS-1:0];
            sh_reg    <= sh_next;
            zero1_reg <= (mask[PIXEL_BITS-1:0] == '0);

            field_reg <= (pix_reg >> sh_reg) & mask_sh;
            den_reg   <= mask_sh;
            zero2_reg <= zero1_reg;
        end
    end

    assign field = field_reg;
    assign den   = den_reg;
    assign zero  = zero2_reg;

endmodule

/* src/mpr_scale_div.sv */
// ----------------------------------------------------------------------------
// mpr_scale_div
// Scales one field by 255 and divides by the shifted mask in a pipelined
// restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module mpr_scale_div #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [PIXEL_BITS-1:0]        field,
    input  logic [PIXEL_BITS-1:0]        den,
    input  logic                         zero,
    output logic [mpr_pkg::CHAN_BITS-1:0] chan
);
    import mpr_pkg::*;

    localparam int W = PIXEL_BITS + CHAN_BITS;

    logic [W-1:0]          num_reg  [DIV_STAGES+1];
    logic [PIXEL_BITS-1:0] den_reg  [DIV_STAGES+1];
    logic [CHAN_BITS-1:0]  q_reg    [DIV_STAGES+1];
    logic                  zero_reg [DIV_STAGES+1];

    logic [W-1:0]          num_next [DIV_STAGES];
    logic [CHAN_BITS-1:0]  q_next   [DIV_STAGES];
    logic [W-1:0]          prod;

    // field * 255 as (field << 8) - field
    assign prod = (W'(field) << CHAN_BITS) - W'(field);

    // Numerator stays below 256 * den since field never exceeds den
    always_comb
    begin
        int k;
        logic [W-1:0] n;
        logic [W-1:0] d;
        logic [CHAN_BITS-1:0] q;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            n = num_reg[s];
            q = q_reg[s];
            for (int b = 0; b < BITS_PER_STAGE; b++)
            begin
                k = CHAN_BITS - 1 - s * BITS_PER_STAGE - b;
                d = W'(den_reg[s]) << k;
                if (n >= d)
                begin
                    n = n - d;
                    q = q | (CHAN_BITS'(1) << k);
                end
            end
            num_next[s] = n;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= prod;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            zero_reg[0] <= zero;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                num_reg[s+1]  <= num_next[s];
                den_reg[s+1]  <= den_reg[s];
                q_reg[s+1]    <= q_next[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    // A zero mask would otherwise divide as all ones
    assign chan = zero_reg[DIV_STAGES] ? '0 : q_reg[DIV_STAGES];

endmodule

/* src/mpr_checker.sv */
// ----------------------------------------------------------------------------
// mpr_port_assert
// Port-level checks for masked_pixel_to_rgb888, bound to the top level.
// ----------------------------------------------------------------------------
module mpr_port_assert (
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [23:0]         m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // Input is never blocked while the output side drains
    a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // An empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    // Nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result presented right after reset");

endmodule

bind masked_pixel_to_rgb888 mpr_port_assert u_mpr_port_assert (.*);

/* test/mpr_checker.sv */
// ----------------------------------------------------------------------------
// mpr_checker
// Watches the mask write channel and both pixel streams of the converter,
// keeps its own copy of the three masks, predicts the RGB888 value of every
// accepted pixel and compares each accepted result against the oldest
// prediction, channel by channel.
// ----------------------------------------------------------------------------
module mpr_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  mpr_pkg::reg_index_t cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [23:0]         m_axis_tdata,
    output int                  mismatches,
    output int                  pending,
    output int                  checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpr_pkg::*;

    // red sits in the low byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    logic [31:0] red_sel;
    logic [31:0] green_sel;
    logic [31:0] blue_sel;
    rgb_t        expected_rgb[$];

    // Align field and mask to the mask's lowest set bit, then scale to 0..255
    function automatic logic [7:0] channel_level(input logic [31:0] pixel,
                                                 input logic [31:0] mask);
        logic [31:0] p;
        logic [31:0] m;
        logic [39:0] scaled;
        p = pixel;
        m = mask;
        if (m == '0)
            return '0;
        while (!m[0])
        begin
            m = m >> 1;
            p = p >> 1;
        end
        scaled = 40'(p & m) * 40'd255;
        return 8'(scaled / 40'(m));
    endfunction

    function automatic rgb_t convert_pixel(input logic [31:0] pixel);
        rgb_t rgb;
        rgb.red   = channel_level(pixel, red_sel);
        rgb.green = channel_level(pixel, green_sel);
        rgb.blue  = channel_level(pixel, blue_sel);
        return rgb;
    endfunction

    function automatic int channel_differs(input string name, input logic [7:0] want,
                                           input logic [7:0] got);
        if (got === want)
            return 0;
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        rgb_t got;
        int   errs;
        if (!rst_n)
        begin
            red_sel   <= RED_MASK_RST;
            green_sel <= GREEN_MASK_RST;
            blue_sel  <= BLUE_MASK_RST;
            expected_rgb.delete();
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_RED_MASK:   red_sel   <= cfg_data;
                    REG_GREEN_MASK: green_sel <= cfg_data;
                    REG_BLUE_MASK:  blue_sel  <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_rgb.size() == 0)
                begin
                    $error("result transaction %h with no pixel outstanding", m_axis_tdata);
                    errs = 1;
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    errs += channel_differs("red_out", want.red, got.red);
                    errs += channel_differs("green_out", want.green, got.green);
                    errs += channel_differs("blue_out", want.blue, got.blue);
                    checked <= checked + 1;
                end
            end
            // masks are only rewritten when idle, so the old values apply here
            if (s_axis_tvalid && s_axis_tready)
                expected_rgb.push_back(convert_pixel(s_axis_tdata));
            mismatches <= mismatches + errs;
            pending    <= expected_rgb.size();
        end
    end

endmodule

/* test/tb_masked_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// tb_masked_pixel_to_rgb888
// Stimulus and verdict for the masked pixel to RGB888 converter.
// A directed pass covers reset masks, zero, full-width, single-bit and
// scattered masks and an ignored register index; random passes then stream
// pixels under fresh masks with varying source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_masked_pixel_to_rgb888;
    import mpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam reg_index_t REG_NONE   = reg_index_t'(2'd3);
    localparam int PHASES             = 8;
    localparam int PIXELS_PER_PHASE   = 106;
    localparam int HOLD_CYCLES        = 40;
    localparam int CYCLE_LIMIT        = 200_000;

    localparam logic [31:0] PIX_DEFAULT [9] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF,
        32'h0080_8080, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555
    };
    localparam logic [31:0] PIX_WIDE [5] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678
    };
    localparam logic [31:0] PIX_NARROW [6] = '{
        32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0F0F_0F00, 32'h0000_0000,
        32'hF0F0_F0F0
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    reg_index_t  cfg_index     = REG_RED_MASK;
    logic [31:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] packed_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] red_out, [15:8] green_out, [23:16] blue_out

    int          mismatches;
    int          pending;
    int          checked;

    logic        pixel_taken   = 1'b0;
    logic        cfg_taken     = 1'b0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    int          hold_asks     = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          cycles        = 0;
    int          pixels_sent   = 0;
    int          mask_settings = 0;
    logic [31:0] red_m         = RED_MASK_RST;
    logic [31:0] green_m       = GREEN_MASK_RST;
    logic [31:0] blue_m        = BLUE_MASK_RST;

    masked_pixel_to_rgb888 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mpr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // transaction flags, read by the drivers at the following falling edge
    always @(posedge clk)
    begin
        pixel_taken <= s_axis_tvalid && s_axis_tready;
        cfg_taken   <= cfg_valid && cfg_ready;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Sink: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen     <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_pixel(input logic [31:0] pixel);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        do @(negedge clk); while (!pixel_taken);
        pixels_sent++;
    endtask

    task automatic cfg_write(input reg_index_t index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_taken);
    endtask

    task automatic program_masks(input logic [31:0] r, input logic [31:0] g,
                                 input logic [31:0] b);
        cfg_write(REG_RED_MASK, r);
        cfg_write(REG_GREEN_MASK, g);
        cfg_write(REG_BLUE_MASK, b);
        cfg_valid <= 1'b0;
        red_m   = r;
        green_m = g;
        blue_m  = b;
        mask_settings++;
    endtask

    // Drop valid and let the pipeline drain before touching the masks
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic [31:0] random_mask();
        int          width;
        int          lsb;
        logic [31:0] m;
        case ($urandom_range(5))
            0, 1:
            begin
                width = $urandom_range(1, 32);
                lsb   = $urandom_range(0, 32 - width);
                m     = 32'(((64'd1 << width) - 64'd1) << lsb);
            end
            2:       m = $urandom;
            3:       m = $urandom & $urandom & $urandom;
            4:       m = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            default: m = $urandom_range(1) ? 32'h0000_0000 : 32'h0000_0001;
        endcase
        return m;
    endfunction

    // Biased towards saturating one channel so full-scale outputs show up
    function automatic logic [31:0] random_pixel();
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return $urandom | red_m;
            3:       return $urandom | green_m;
            4:       return $urandom | blue_m;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset masks first
        foreach (PIX_DEFAULT[i])
            send_pixel(PIX_DEFAULT[i]);
        drain();
        // full-width, zero and scattered masks; the unused index must be ignored
        cfg_write(REG_NONE, $urandom);
        program_masks(32'hFFFF_FFFF, 32'h0000_0000, 32'hA500_0081);
        foreach (PIX_WIDE[i])
            send_pixel(PIX_WIDE[i]);
        drain();
        program_masks(32'h8000_0000, 32'h0000_0001, 32'h0F0F_0F0F);
        foreach (PIX_NARROW[i])
            send_pixel(PIX_NARROW[i]);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_idle_pct  = 63;
                    rx_stall_pct <= 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 63;
                end
                default:
                begin
                    tx_idle_pct  = 38;
                    rx_stall_pct <= 38;
                end
            endcase
            program_masks(random_mask(), random_mask(), random_mask());
            // back-to-back pixels into a held sink fill the pipe and stall the source
            if (ph % 4 == 0)
                hold_asks <= hold_asks + 1;
            repeat (PIXELS_PER_PHASE)
                send_pixel(random_pixel());
            drain();
        end

        repeat (LATENCY + 4) @(negedge clk);
        $display("Checked %0d RGB results from %0d pixels across %0d mask settings,",
                 checked, pixels_sent, mask_settings);
        $display("with zero, full, single-bit and scattered masks, gaps and a long sink stall.");
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
